[src/lbto_pkg.sv]
// ----------------------------------------------------------------------------
// lbto_pkg: shared types and constants for the LED blink generator
// Item kinds, field widths and the packed layout of the stream payloads.
// ----------------------------------------------------------------------------
package lbto_pkg;

	localparam int unsigned FIELD_W     = 8;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned IN_DATA_W   = 4 * FIELD_W;
	localparam int unsigned OUT_DATA_W  = 16;
	localparam logic [FIELD_W-1:0] RESET_PERIOD = 8'd255;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 2'd0,
		KIND_SET     = 2'd1,
		KIND_SET_FOR = 2'd2,
		KIND_LOAD    = 2'd3
	} kind_t;

	// Input item as held in the input register
	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] countdown_load;
		logic [FIELD_W-1:0] override_periods;
		logic [FIELD_W-1:0] on_phase;
		logic [FIELD_W-1:0] blink_period;
	} item_t;

	// Result item, lowest field in the lowest bits of tdata
	typedef struct packed {
		logic [OUT_DATA_W-11:0] pad;
		logic                   override_active;
		logic [FIELD_W-1:0]     countdown_value;
		logic                   led_drive;
	} result_t;

endpackage

[src/led_blink_with_timed_override_top.sv]
// ----------------------------------------------------------------------------
// led_blink_with_timed_override_top: LED blink generator with timed override
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_axis   in   blink_period, on_phase, override_periods,  kind
//                 countdown_load (32 bits)
//   m_axis   out  led_drive, countdown_value,                -
//                 override_active, zero pad (16 bits)
//
// One item per cycle while m_axis does not stall; each item's result goes
// through the input register, then the result register, to m_axis.
// The pattern state is read and written in the single stage after the input
// register, so consecutive items see each other's effects with no gap.
// Reset clears the pattern to period 255, duty 0, LED off, countdown 0.
// A stall on m_axis fills the result register, then the input register;
// tready falls only when both are full.
// ----------------------------------------------------------------------------
module led_blink_with_timed_override_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// blink_period[7:0], on_phase[15:8], override_periods[23:16], countdown_load[31:24]
	input  logic [lbto_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [lbto_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// led_drive[0], countdown_value[8:1], override_active[9], zero[15:10]
	output logic [lbto_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import lbto_pkg::*;

	logic               valid_s1;
	item_t              item_s1;
	logic               advance;

	logic [FIELD_W-1:0] phase_q, period_q, duty_q, saved_period_q, saved_duty_q;
	logic [FIELD_W-1:0] left_q, countdown_q;
	logic               led_q;

	logic [FIELD_W-1:0] phase_d, period_d, duty_d, saved_period_d, saved_duty_d;
	logic [FIELD_W-1:0] left_d, countdown_d;
	logic               led_d;
	logic [FIELD_W-1:0] phase_inc;
	logic               wrap;

	logic               out_valid_q;
	result_t            out_q;
	result_t            res_d;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= {kind_t'(s_axis_tuser), s_axis_tdata};
		end
	end

	always_comb begin
		phase_d        = phase_q;
		period_d       = period_q;
		duty_d         = duty_q;
		saved_period_d = saved_period_q;
		saved_duty_d   = saved_duty_q;
		left_d         = left_q;
		countdown_d    = countdown_q;
		led_d          = led_q;
		phase_inc      = phase_q + 8'd1;
		wrap           = phase_inc > period_q;
		case (item_s1.kind)
			KIND_TICK: begin
				phase_d = wrap ? '0 : phase_inc;
				if (wrap && left_q != '0) begin
					left_d = left_q - 8'd1;
					// restore the saved pattern once the last period ends
					if (left_q == 8'd1) begin
						period_d = saved_period_q;
						duty_d   = saved_duty_q;
					end
				end
				led_d = phase_d < duty_d;
				if (countdown_q != '0) begin
					countdown_d = countdown_q - 8'd1;
				end
			end
			KIND_SET: begin
				period_d = item_s1.blink_period;
				duty_d   = item_s1.on_phase;
				left_d   = '0;
			end
			KIND_SET_FOR: begin
				// keep the pre-override pattern if one is already running
				if (left_q == '0) begin
					saved_period_d = period_q;
					saved_duty_d   = duty_q;
				end
				period_d = item_s1.blink_period;
				duty_d   = item_s1.on_phase;
				left_d   = item_s1.override_periods;
			end
			KIND_LOAD: begin
				countdown_d = item_s1.countdown_load;
			end
			default: begin
			end
		endcase
		res_d                 = '0;
		res_d.led_drive       = led_d;
		res_d.countdown_value = countdown_d;
		res_d.override_active = left_d != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= '0;
			period_q       <= RESET_PERIOD;
			duty_q         <= '0;
			saved_period_q <= '0;
			saved_duty_q   <= '0;
			left_q         <= '0;
			countdown_q    <= '0;
			led_q          <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			period_q       <= period_d;
			duty_q         <= duty_d;
			saved_period_q <= saved_period_d;
			saved_duty_q   <= saved_duty_d;
			left_q         <= left_d;
			countdown_q    <= countdown_d;
			led_q          <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

[src/lbto_checker.sv]
// ----------------------------------------------------------------------------
// lbto_checker: port-level checks for the LED blink generator
// Tracks items in flight and checks results against their item kinds.
// ----------------------------------------------------------------------------
module lbto_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [lbto_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [lbto_pkg::KIND_W-1:0]     s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lbto_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import lbto_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] load;
	} track_t;

	logic         in_acc, out_acc;
	logic [1:0]   cnt_q;
	logic         slot;
	track_t       trk_q [2];
	track_t       head;
	track_t       new_trk;
	result_t      res;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	// entry the new item lands in once the head has shifted out
	assign slot    = cnt_q[1] || (cnt_q[0] && !out_acc);
	assign head    = trk_q[0];
	assign new_trk = {s_axis_tuser, s_axis_tdata[IN_DATA_W-1 -: FIELD_W]};
	assign res     = m_axis_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// shift out the head on a result, then append the new item
	always_ff @(posedge clk) begin
		if (out_acc) begin
			trk_q[0] <= (in_acc && !slot) ? new_trk : trk_q[1];
		end else if (in_acc && !slot) begin
			trk_q[0] <= new_trk;
		end
		if (in_acc && slot) begin
			trk_q[1] <= new_trk;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q != 2'd0)
		else $error("result with no item in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("more items in flight than stages");

	a_set_cancels: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && head.kind == KIND_SET |-> !res.override_active)
		else $error("set item left an override running");

	a_load_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && head.kind == KIND_LOAD |-> res.countdown_value == head.load)
		else $error("load item reported wrong countdown");

endmodule

bind led_blink_with_timed_override_top lbto_checker u_lbto_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[test/tb_led_blink_with_timed_override_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_blink_with_timed_override_top: stream testbench for the LED blink block
// Drives tick, set, temporary-set and countdown-load items into s_axis and
// predicts each result from its own copy of the pattern, override and
// countdown state. Results on m_axis are checked field by field in order.
// Phases vary sender idling and receiver stalling, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_led_blink_with_timed_override_top;
	import lbto_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASE_ITEMS  = 240;

	typedef struct {
		kind_t              kind;
		logic [FIELD_W-1:0] period;
		logic [FIELD_W-1:0] duty;
		logic [FIELD_W-1:0] periods;
		logic [FIELD_W-1:0] load;
	} stim_item_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [KIND_W-1:0]     s_axis_tuser  = KIND_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	stim_item_t stim_queue[$];
	result_t    led_results_due[$];
	stim_item_t offered;
	result_t    predicted;
	result_t    seen;
	result_t    wanted;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_request  = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;

	// predicted block state, reset values
	logic [FIELD_W-1:0] phase_pos     = '0;
	logic [FIELD_W-1:0] cur_period    = RESET_PERIOD;
	logic [FIELD_W-1:0] cur_duty      = '0;
	logic [FIELD_W-1:0] keep_period   = '0;
	logic [FIELD_W-1:0] keep_duty     = '0;
	logic [FIELD_W-1:0] override_left = '0;
	logic [FIELD_W-1:0] countdown_q   = '0;
	logic               led_on        = 1'b0;

	led_blink_with_timed_override_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic predict_led_result(input stim_item_t it, output result_t r);
		case (it.kind)
			KIND_TICK: begin
				phase_pos = phase_pos + 8'd1;
				if (phase_pos > cur_period) begin
					phase_pos = '0;
					if (override_left != 0) begin
						override_left = override_left - 8'd1;
						if (override_left == 0) begin
							cur_period = keep_period;
							cur_duty   = keep_duty;
						end
					end
				end
				led_on = (phase_pos < cur_duty);
				if (countdown_q != 0)
					countdown_q = countdown_q - 8'd1;
			end
			KIND_SET: begin
				cur_period    = it.period;
				cur_duty      = it.duty;
				override_left = '0;
			end
			KIND_SET_FOR: begin
				// keep the pair from before the first override
				if (override_left == 0) begin
					keep_period = cur_period;
					keep_duty   = cur_duty;
				end
				cur_period    = it.period;
				cur_duty      = it.duty;
				override_left = it.periods;
			end
			default: begin
				countdown_q = it.load;
			end
		endcase
		r                 = '0;
		r.led_drive       = led_on;
		r.countdown_value = countdown_q;
		r.override_active = (override_left != 0);
	endtask

	task automatic add_item(input kind_t k, input logic [7:0] p, input logic [7:0] d,
			input logic [7:0] n, input logic [7:0] l);
		stim_item_t it;
		it.kind    = k;
		it.period  = p;
		it.duty    = d;
		it.periods = n;
		it.load    = l;
		stim_queue.push_back(it);
	endtask

	// mostly short periods so that overrides expire often
	function automatic stim_item_t random_item();
		stim_item_t  it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 68)
			it.kind = KIND_TICK;
		else if (pick < 76)
			it.kind = KIND_SET;
		else if (pick < 88)
			it.kind = KIND_SET_FOR;
		else
			it.kind = KIND_LOAD;
		pick = $urandom_range(9);
		if (pick < 7)
			it.period = 8'($urandom_range(5));
		else if (pick == 7)
			it.period = RESET_PERIOD;
		else
			it.period = 8'($urandom);
		if ($urandom_range(3) == 0)
			it.duty = 8'($urandom);
		else
			it.duty = 8'($urandom_range(int'(it.period) + 1));
		if ($urandom_range(7) == 0)
			it.periods = 8'($urandom);
		else
			it.periods = 8'($urandom_range(3));
		if ($urandom_range(3) == 0)
			it.load = 8'($urandom_range(3));
		else
			it.load = 8'($urandom);
		return it;
	endfunction

	task automatic drain();
		while (stim_queue.size() != 0 || led_results_due.size() != 0 || s_axis_tvalid)
			@(negedge clk);
	endtask

	// driver: hold an offered item until taken, then pop the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= KIND_TICK;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_led_result(offered, predicted);
				led_results_due.push_back(predicted);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (stim_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = stim_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {offered.load, offered.periods, offered.duty, offered.period};
					s_axis_tuser  <= offered.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left   <= 0;
			hold_served <= 0;
		end else if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left   <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left   <= hold_left - 1;
		end
	end

	// monitor: check taken results, then choose the next tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = result_t'(m_axis_tdata);
				if (led_results_due.size() == 0) begin
					flag_error($sformatf("result %h with none expected", m_axis_tdata));
				end else begin
					wanted = led_results_due.pop_front();
					if (seen.led_drive !== wanted.led_drive)
						flag_error($sformatf("led_drive %b, expected %b",
							seen.led_drive, wanted.led_drive));
					if (seen.countdown_value !== wanted.countdown_value)
						flag_error($sformatf("countdown_value %0d, expected %0d",
							seen.countdown_value, wanted.countdown_value));
					if (seen.override_active !== wanted.override_active)
						flag_error($sformatf("override_active %b, expected %b",
							seen.override_active, wanted.override_active));
					if (seen.pad !== '0)
						flag_error($sformatf("pad bits %b, expected zero", seen.pad));
				end
			end
			if (hold_request != hold_served || hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state, unused fields, countdown floor, overrides
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'hff, 8'hff, 8'hff, 8'hff);
		add_item(KIND_LOAD,    8'h00, 8'h00, 8'h00, 8'hff);
		add_item(KIND_LOAD,    8'hff, 8'hff, 8'hff, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_LOAD,    8'h00, 8'h00, 8'h00, 8'h02);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_SET,     8'h00, 8'hff, 8'haa, 8'h55);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_SET_FOR, 8'h01, 8'h01, 8'h02, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_SET_FOR, 8'h02, 8'h01, 8'h03, 8'h00);
		add_item(KIND_SET_FOR, 8'h00, 8'h00, 8'h01, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_SET_FOR, 8'h03, 8'h02, 8'h00, 8'h00);
		add_item(KIND_SET_FOR, 8'h00, 8'h00, 8'h05, 8'h00);
		add_item(KIND_SET,     8'hff, 8'h80, 8'h00, 8'h00);
		add_item(KIND_SET_FOR, 8'hff, 8'hff, 8'h01, 8'h00);
		add_item(KIND_TICK,    8'h00, 8'h00, 8'h00, 8'h00);
		add_item(KIND_SET,     8'h04, 8'h02, 8'h00, 8'h00);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 73; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 73; end
				default: begin send_idle_pct = 37; stall_pct = 37; end
			endcase
			if (ph == 0) begin
				// long hold-off while the sender keeps offering
				hold_request++;
				// period 255 under override: the counter wraps without ending a period
				add_item(KIND_SET_FOR, RESET_PERIOD, 8'($urandom_range(1, 254)), 8'h02,
					8'h00);
				repeat (270)
					add_item(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
			end
			repeat (PHASE_ITEMS)
				stim_queue.push_back(random_item());
			drain();
		end

		// let any stray result surface
		repeat (10) @(negedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
